@@ src/lew_pkg.sv @@
// Shared constants and types of the line editor with word wrap.
package lew_pkg;

  localparam int unsigned DefLineLen = 16;

  localparam logic [7:0] CH_BELL     = 8'd7;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_EOF      = 8'd4;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SP       = 8'd32;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  localparam logic [7:0] KillReset   = 8'd21;
  localparam logic [7:0] WeraseReset = 8'd23;

  typedef enum logic [0:0] {
    REG_KILL   = 1'b0,
    REG_WERASE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_KILL,
    ST_WERASE,
    ST_NL_CELL,
    ST_NL_TAIL,
    ST_WR_SCAN,
    ST_WR_ECHO,
    ST_WR_FULL_RD,
    ST_WR_FULL,
    ST_WR_FULL_NL,
    ST_WR_CHAR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       sess_end;
  } result_t;

endpackage

@@ src/line_editor_with_word_wrap.sv @@
// Line editor with word wrap: top level with line memory, wrap scratch memory and sequencer.
//
// Usage: keyboard bytes enter on the input channel (in_valid_i, in_stall_o, in_byte_i).
// Each accepted item yields zero or more echo results on the output channel
// (out_valid_o, out_stall_i and the result fields); last_o marks the final result
// of an item. The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i,
// cfg_data_i) sets the kill and word-erase codes; write it only while idle.
// The sequencer handles one item at a time; kill, word erase, newline and wrap walk
// the line memory one cell per cycle while the sequencer is not waiting on the
// result buffer. The line memory has one read and one write port with registered
// read data, which sets the one-cell-per-cycle pace. A stalled receiver holds the
// output register; the sequencer waits while its one-entry result buffer is full
// and the output register cannot take its entry.
// Reset clears the line to spaces through per-cell valid bits, sets the cursor
// to zero, clears the session-end flag and loads the default control codes.
// After an end-of-file on an empty line, further items are taken and dropped.
module line_editor_with_word_wrap import lew_pkg::*; #(
  parameter int unsigned LINE_LEN = DefLineLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       session_end_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(LINE_LEN + 1);
  localparam int unsigned AW = $clog2(LINE_LEN);
  localparam logic [CW-1:0] LenC   = CW'(LINE_LEN);
  localparam logic [CW-1:0] LastC  = CW'(LINE_LEN - 1);
  localparam logic [CW-1:0] OneC   = CW'(1);

  state_e state_q, state_d;

  logic [7:0]    c_q;
  logic [7:0]    kill_q, werase_q;
  logic [CW-1:0] cur_q, cur_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] w_q, w_d;
  logic          finished_q, finished_d;
  logic          in_word_q, in_word_d;

  // Line memory with per-cell valid bits; an invalid cell reads as a space.
  logic [7:0]          cell_mem [LINE_LEN];
  logic [LINE_LEN-1:0] vld_q;
  logic [7:0]          cell_rdata_q;
  logic                cell_rvld_q;
  logic [7:0]          scr_mem [LINE_LEN];
  logic [7:0]          scr_rdata_q;

  result_t pend_q, out_q, push_res;
  logic    pend_valid_q, pend_last_q;
  logic    out_valid_q, out_last_q;

  logic          accept, out_free, push_ok, pend_move, push, set_last;
  logic          cell_we, cell_re, vld_clr, vld_clr_all, scr_we, scr_re;
  logic [AW-1:0] cell_waddr, cell_raddr, vld_clr_addr, scr_waddr, scr_raddr;
  logic [7:0]    cell_wdata, scr_wdata, cell_val;
  logic          cell_sp, printable;
  logic [CW-1:0] cur_m1, k_m1, k_m2, k_p1, j_p1;

  assign accept    = in_valid_i & ~in_stall_o;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign push_ok   = ~pend_valid_q | out_free;
  assign pend_move = pend_valid_q & out_free & (push | pend_last_q);

  assign cell_val  = cell_rvld_q ? cell_rdata_q : CH_SP;
  assign cell_sp   = (cell_val == CH_SP);
  assign printable = (c_q >= CH_PRINT_LO) && (c_q <= CH_PRINT_HI);

  assign cur_m1 = cur_q - OneC;
  assign k_m1   = k_q - OneC;
  assign k_m2   = k_q - CW'(2);
  assign k_p1   = k_q + OneC;
  assign j_p1   = j_q + OneC;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !finished_q) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (c_q == CH_BS) begin
          if (cur_q == '0) state_d = ST_IDLE;
          else if (push_ok) state_d = ST_FIN;
        end else if (c_q == CH_EOF && cur_q == '0) begin
          if (push_ok) state_d = ST_FIN;
        end else if (c_q == kill_q) begin
          state_d = (cur_q == '0) ? ST_IDLE : ST_KILL;
        end else if (c_q == werase_q) begin
          state_d = (cur_q == '0) ? ST_IDLE : ST_WERASE;
        end else if (c_q == CH_NL) begin
          if (push_ok) state_d = ST_NL_CELL;
        end else if (!printable) begin
          if (push_ok) state_d = ST_FIN;
        end else if (cur_q != LenC) begin
          if (push_ok) state_d = ST_FIN;
        end else begin
          state_d = ST_WR_SCAN;
        end
      end
      ST_KILL: begin
        if (push_ok && cur_q == OneC) state_d = ST_FIN;
      end
      ST_WERASE: begin
        if (cell_sp && in_word_q) state_d = ST_FIN;
        else if (push_ok && k_q == OneC) state_d = ST_FIN;
      end
      ST_NL_CELL: begin
        if (push_ok && k_q == LastC) state_d = ST_NL_TAIL;
      end
      ST_NL_TAIL: begin
        if (push_ok) state_d = ST_FIN;
      end
      ST_WR_SCAN: begin
        if (push_ok) begin
          if (!cell_sp) begin
            if (k_q == OneC) state_d = ST_WR_FULL_RD;
          end else begin
            state_d = (k_q == LenC) ? ST_WR_CHAR : ST_WR_ECHO;
          end
        end
      end
      ST_WR_ECHO: begin
        if (push_ok && j_q == LastC) state_d = ST_WR_CHAR;
      end
      ST_WR_FULL_RD: state_d = ST_WR_FULL;
      ST_WR_FULL: begin
        if (push_ok && j_q == LastC) state_d = ST_WR_FULL_NL;
      end
      ST_WR_FULL_NL: begin
        if (push_ok) state_d = ST_WR_CHAR;
      end
      ST_WR_CHAR: begin
        if (push_ok) state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer actions: results, memory accesses and counter updates.
  always_comb begin
    push         = 1'b0;
    push_res     = '0;
    set_last     = 1'b0;
    cell_we      = 1'b0;
    cell_waddr   = '0;
    cell_wdata   = c_q;
    cell_re      = 1'b0;
    cell_raddr   = '0;
    vld_clr      = 1'b0;
    vld_clr_all  = 1'b0;
    vld_clr_addr = '0;
    scr_we       = 1'b0;
    scr_waddr    = '0;
    scr_wdata    = cell_val;
    scr_re       = 1'b0;
    scr_raddr    = '0;
    cur_d        = cur_q;
    k_d          = k_q;
    j_d          = j_q;
    w_d          = w_q;
    finished_d   = finished_q;
    in_word_d    = in_word_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_DECODE: begin
        priority if (c_q == CH_BS) begin
          if (cur_q != '0 && push_ok) begin
            push          = 1'b1;
            push_res.kind = 1'b1;
            vld_clr       = 1'b1;
            vld_clr_addr  = cur_m1[AW-1:0];
            cur_d         = cur_m1;
          end
        end else if (c_q == CH_EOF && cur_q == '0) begin
          if (push_ok) begin
            push              = 1'b1;
            push_res.data     = CH_NL;
            push_res.sess_end = 1'b1;
            finished_d        = 1'b1;
          end
        end else if (c_q == kill_q) begin
          // The kill walk needs no cell contents.
        end else if (c_q == werase_q) begin
          if (cur_q != '0) begin
            cell_re    = 1'b1;
            cell_raddr = cur_m1[AW-1:0];
            k_d        = cur_q;
            in_word_d  = 1'b0;
          end
        end else if (c_q == CH_NL) begin
          if (push_ok) begin
            push          = 1'b1;
            push_res.data = CH_NL;
            cell_re       = 1'b1;
            cell_raddr    = '0;
            k_d           = '0;
          end
        end else if (!printable) begin
          if (push_ok) begin
            push          = 1'b1;
            push_res.data = CH_BELL;
          end
        end else if (cur_q != LenC) begin
          if (push_ok) begin
            push          = 1'b1;
            push_res.data = c_q;
            cell_we       = 1'b1;
            cell_waddr    = cur_q[AW-1:0];
            cur_d         = cur_q + OneC;
          end
        end else begin
          // Full line: scan the trailing word from the end.
          cell_re    = 1'b1;
          cell_raddr = AW'(LINE_LEN - 1);
          k_d        = LenC;
          w_d        = '0;
        end
      end
      ST_KILL: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.kind = 1'b1;
          vld_clr       = 1'b1;
          vld_clr_addr  = cur_m1[AW-1:0];
          cur_d         = cur_m1;
        end
      end
      ST_WERASE: begin
        if (cell_sp && in_word_q) begin
          cur_d = k_q;
        end else if (push_ok) begin
          push = 1'b1;
          if (cell_sp) begin
            push_res.data = CH_BS;
          end else begin
            push_res.kind = 1'b1;
            vld_clr       = 1'b1;
            vld_clr_addr  = k_m1[AW-1:0];
            in_word_d     = 1'b1;
          end
          k_d = k_m1;
          if (k_q == OneC) begin
            cur_d = '0;
          end else begin
            cell_re    = 1'b1;
            cell_raddr = k_m2[AW-1:0];
          end
        end
      end
      ST_NL_CELL: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.data = cell_val;
          if (k_q != LastC) begin
            k_d        = k_p1;
            cell_re    = 1'b1;
            cell_raddr = k_p1[AW-1:0];
          end
        end
      end
      ST_NL_TAIL: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.data = CH_NL;
          vld_clr_all   = 1'b1;
          cur_d         = '0;
        end
      end
      ST_WR_SCAN: begin
        if (push_ok) begin
          push = 1'b1;
          if (!cell_sp) begin
            push_res.kind = 1'b1;
            vld_clr       = 1'b1;
            vld_clr_addr  = k_m1[AW-1:0];
            scr_we        = 1'b1;
            scr_waddr     = k_m1[AW-1:0];
            k_d           = k_m1;
            if (k_q != OneC) begin
              cell_re    = 1'b1;
              cell_raddr = k_m2[AW-1:0];
            end
          end else begin
            // The word moves to the start of a fresh line.
            push_res.data = CH_NL;
            vld_clr_all   = 1'b1;
            j_d           = k_q;
            if (k_q != LenC) begin
              scr_re    = 1'b1;
              scr_raddr = k_q[AW-1:0];
            end
          end
        end
      end
      ST_WR_ECHO: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.data = scr_rdata_q;
          cell_we       = 1'b1;
          cell_waddr    = w_q[AW-1:0];
          cell_wdata    = scr_rdata_q;
          w_d           = w_q + OneC;
          if (j_q != LastC) begin
            j_d       = j_p1;
            scr_re    = 1'b1;
            scr_raddr = j_p1[AW-1:0];
          end
        end
      end
      ST_WR_FULL_RD: begin
        scr_re    = 1'b1;
        scr_raddr = '0;
        j_d       = '0;
      end
      ST_WR_FULL: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.data = scr_rdata_q;
          if (j_q != LastC) begin
            j_d       = j_p1;
            scr_re    = 1'b1;
            scr_raddr = j_p1[AW-1:0];
          end
        end
      end
      ST_WR_FULL_NL: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.data = CH_NL;
        end
      end
      ST_WR_CHAR: begin
        if (push_ok) begin
          push          = 1'b1;
          push_res.data = c_q;
          cell_we       = 1'b1;
          cell_waddr    = w_q[AW-1:0];
          cur_d         = w_q + OneC;
        end
      end
      ST_FIN: set_last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      finished_q   <= 1'b0;
      in_word_q    <= 1'b0;
      vld_q        <= '0;
      kill_q       <= KillReset;
      werase_q     <= WeraseReset;
      pend_valid_q <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      finished_q <= finished_d;
      in_word_q  <= in_word_d;

      if (vld_clr_all) begin
        vld_q <= '0;
      end else begin
        if (cell_we) vld_q[cell_waddr] <= 1'b1;
        if (vld_clr) vld_q[vld_clr_addr] <= 1'b0;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_KILL:   kill_q   <= cfg_data_i;
          REG_WERASE: werase_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (push) pend_valid_q <= 1'b1;
      else if (pend_move) pend_valid_q <= 1'b0;

      if (push) pend_last_q <= 1'b0;
      else if (set_last) pend_last_q <= 1'b1;

      if (pend_move) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) c_q <= in_byte_i;
    k_q <= k_d;
    j_q <= j_d;
    w_q <= w_d;
    if (push) pend_q <= push_res;
    if (pend_move) begin
      out_q      <= pend_q;
      out_last_q <= pend_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cell_re) begin
      cell_rdata_q <= cell_mem[cell_raddr];
      cell_rvld_q  <= vld_q[cell_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    if (scr_re) scr_rdata_q <= scr_mem[scr_raddr];
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_q.kind;
  assign out_byte_o    = out_q.data;
  assign session_end_o = out_q.sess_end;
  assign last_o        = out_last_q;

endmodule

@@ src/lew_checker.sv @@
// Port-level checker of the line editor with word wrap and its bind.
module lew_checker import lew_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic       out_kind_i,
  input logic [7:0] out_byte_i,
  input logic       session_end_i,
  input logic       last_i
);

  logic seen_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_end_q <= 1'b0;
    end else if (out_valid_i && !out_stall_i && session_end_i) begin
      seen_end_q <= 1'b1;
    end
  end

  // The session-end item is a lone newline that closes its input item.
  a_end_is_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && session_end_i |-> out_byte_i == CH_NL && !out_kind_i && last_i)
    else $error("session end without a plain final newline");

  a_erase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i |-> out_byte_i == 8'd0)
    else $error("erase item carries a nonzero byte");

  // Nothing follows once the session has ended.
  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_end_q |-> !out_valid_i)
    else $error("output after session end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_kind_i) && $stable(last_i) && $stable(session_end_i))
    else $error("stalled output item changed");

endmodule

bind line_editor_with_word_wrap lew_checker u_lew_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_kind_i    (out_kind_o),
  .out_byte_i    (out_byte_o),
  .session_end_i (session_end_o),
  .last_i        (last_o)
);
